[rtl/gcpp_pkg.sv]
package gcpp_pkg;

    localparam int WORD_W   = 32;
    localparam int COUNT_W  = 14;
    localparam int LEFT_W   = 15;
    localparam int ADDR_W   = 16;
    localparam int CFG_W    = 15;
    localparam int OPC_W    = 8;
    localparam int TYPE_W   = 2;
    localparam int REGIDX_W = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [TYPE_W-1:0] PKT_TYPE0 = 2'd0;
    localparam logic [TYPE_W-1:0] PKT_TYPE1 = 2'd1;
    localparam logic [TYPE_W-1:0] PKT_TYPE2 = 2'd2;
    localparam logic [TYPE_W-1:0] PKT_TYPE3 = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_IB_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IB_SIZE = 1'd1;

    typedef enum logic [2:0] {
        KIND_HEADER     = 3'd0,
        KIND_REG_WRITE  = 3'd1,
        KIND_T3_PAYLOAD = 3'd2,
        KIND_TYPE1_ERR  = 3'd3,
        KIND_TYPE2_HDR  = 3'd4
    } t_word_kind;

    typedef struct packed {
        logic [WORD_W-1:0] command_word;
        logic              start_of_buffer;
    } t_cmd;

    typedef struct packed {
        logic                 en;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [WORD_W-1:0]    data;
    } t_cfg_wr;

    typedef struct packed {
        t_word_kind         word_kind;
        logic [TYPE_W-1:0]  header_type;
        logic [COUNT_W-1:0] payload_count;
        logic [ADDR_W-1:0]  reg_address;
        logic [WORD_W-1:0]  write_value;
        logic [OPC_W-1:0]   opcode_tag;
        logic               last_of_packet;
        logic               ib_request;
        logic [WORD_W-1:0]  ib_address;
        logic [WORD_W-1:0]  ib_size;
    } t_result;

endpackage

[rtl/gcpp_if.sv]
interface gcpp_cmd_if import gcpp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] command_word;
    logic              start_of_buffer;

    modport source (output valid, output command_word, output start_of_buffer, input ready);
    modport sink   (input valid, input command_word, input start_of_buffer, output ready);
endinterface

interface gcpp_res_if import gcpp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         word_kind;
    logic [TYPE_W-1:0]  header_type;
    logic [COUNT_W-1:0] payload_count;
    logic [ADDR_W-1:0]  reg_address;
    logic [WORD_W-1:0]  write_value;
    logic [OPC_W-1:0]   opcode_tag;
    logic               last_of_packet;
    logic               ib_request;
    logic [WORD_W-1:0]  ib_address;
    logic [WORD_W-1:0]  ib_size;

    modport source (
        output valid, output word_kind, output header_type, output payload_count,
        output reg_address, output write_value, output opcode_tag,
        output last_of_packet, output ib_request, output ib_address, output ib_size,
        input ready
    );
    modport sink (
        input valid, input word_kind, input header_type, input payload_count,
        input reg_address, input write_value, input opcode_tag,
        input last_of_packet, input ib_request, input ib_address, input ib_size,
        output ready
    );
endinterface

interface gcpp_cfg_if import gcpp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

[rtl/gcpp_in_stage.sv]
module gcpp_in_stage import gcpp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gcpp_cmd_if.sink   i_cmd,
    input  logic       i_advance,
    output logic       o_valid,
    output t_cmd       o_cmd
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    logic take;

    assign i_cmd.ready = !r_valid || i_advance;
    assign take        = i_cmd.valid && i_cmd.ready;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd.command_word    <= i_cmd.command_word;
            r_cmd.start_of_buffer <= i_cmd.start_of_buffer;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

[rtl/gcpp_parser.sv]
module gcpp_parser import gcpp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg_wr,
    input  logic    i_step,
    input  t_cmd    i_cmd,
    output t_result o_result
);

    logic [CFG_W-1:0]   r_ib_base_reg;
    logic [CFG_W-1:0]   r_ib_size_reg;
    logic               r_in_payload;
    logic [LEFT_W-1:0]  r_words_left;
    logic [ADDR_W-1:0]  r_next_addr;
    logic               r_fixed;
    logic [TYPE_W-1:0]  r_type;
    logic [COUNT_W-1:0] r_count;
    logic [OPC_W-1:0]   r_opcode;
    logic [WORD_W-1:0]  r_ib_base;

    logic               n_in_payload;
    logic [LEFT_W-1:0]  n_words_left;
    logic [ADDR_W-1:0]  n_next_addr;
    logic               n_fixed;
    logic [TYPE_W-1:0]  n_type;
    logic [COUNT_W-1:0] n_count;
    logic [OPC_W-1:0]   n_opcode;
    logic [WORD_W-1:0]  n_ib_base;

    logic [WORD_W-1:0]  w;
    logic [ADDR_W-1:0]  hdr_addr;
    logic [LEFT_W-1:0]  left_dec;
    logic               base_hit;
    logic               size_hit;

    assign w        = i_cmd.command_word;
    assign hdr_addr = {1'b0, w[REGIDX_W-1:0], 2'b00};
    assign left_dec = (r_words_left != '0) ? (r_words_left - LEFT_W'(1)) : '0;
    assign base_hit = (r_next_addr == {1'b0, r_ib_base_reg});
    assign size_hit = (r_next_addr == {1'b0, r_ib_size_reg});

    always_comb begin
        n_in_payload = r_in_payload;
        n_words_left = r_words_left;
        n_next_addr  = r_next_addr;
        n_fixed      = r_fixed;
        n_type       = r_type;
        n_count      = r_count;
        n_opcode     = r_opcode;
        n_ib_base    = r_ib_base;
        o_result     = '0;
        o_result.word_kind = KIND_HEADER;

        if (i_cmd.start_of_buffer || !r_in_payload) begin
            n_type       = w[31:30];
            n_count      = w[29:16];
            n_opcode     = w[15:8];
            n_fixed      = w[15];
            n_next_addr  = hdr_addr;
            n_words_left = '0;
            n_in_payload = 1'b0;
            case (n_type)
                PKT_TYPE0: begin
                    o_result.word_kind   = KIND_HEADER;
                    o_result.reg_address = hdr_addr;
                    n_in_payload         = 1'b1;
                    n_words_left         = {1'b0, n_count} + LEFT_W'(1);
                end
                PKT_TYPE1: begin
                    o_result.word_kind      = KIND_TYPE1_ERR;
                    o_result.last_of_packet = 1'b1;
                end
                PKT_TYPE2: begin
                    o_result.word_kind      = KIND_TYPE2_HDR;
                    o_result.reg_address    = hdr_addr;
                    o_result.last_of_packet = 1'b1;
                end
                default: begin
                    o_result.word_kind = KIND_HEADER;
                    n_in_payload       = 1'b1;
                    n_words_left       = {1'b0, n_count} + LEFT_W'(1);
                end
            endcase
        end else begin
            o_result.write_value = w;
            n_words_left         = left_dec;
            if (left_dec == '0) begin
                o_result.last_of_packet = 1'b1;
                n_in_payload            = 1'b0;
            end
            if (r_type == PKT_TYPE0) begin
                o_result.word_kind   = KIND_REG_WRITE;
                o_result.reg_address = r_next_addr;
                if (!r_fixed) begin
                    n_next_addr = r_next_addr + ADDR_W'(4);
                end
                if (base_hit) begin
                    n_ib_base = w;
                end
                if (size_hit) begin
                    o_result.ib_request = 1'b1;
                    o_result.ib_address = base_hit ? w : r_ib_base;
                    o_result.ib_size    = w;
                    n_ib_base           = '0;
                end
            end else begin
                o_result.word_kind = KIND_T3_PAYLOAD;
            end
        end

        o_result.header_type   = n_type;
        o_result.payload_count = n_count;
        o_result.opcode_tag    = (n_type == PKT_TYPE3) ? n_opcode : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ib_base_reg <= '0;
            r_ib_size_reg <= '0;
        end else if (i_cfg_wr.en) begin
            case (i_cfg_wr.reg_index)
                CFG_IB_BASE: r_ib_base_reg <= i_cfg_wr.data[CFG_W-1:0];
                CFG_IB_SIZE: r_ib_size_reg <= i_cfg_wr.data[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_words_left <= '0;
            r_next_addr  <= '0;
            r_fixed      <= 1'b0;
            r_type       <= '0;
            r_count      <= '0;
            r_opcode     <= '0;
            r_ib_base    <= '0;
        end else if (i_step) begin
            r_in_payload <= n_in_payload;
            r_words_left <= n_words_left;
            r_next_addr  <= n_next_addr;
            r_fixed      <= n_fixed;
            r_type       <= n_type;
            r_count      <= n_count;
            r_opcode     <= n_opcode;
            r_ib_base    <= n_ib_base;
        end
    end

endmodule

[rtl/gcpp_out_stage.sv]
module gcpp_out_stage import gcpp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_result,
    output logic       o_advance,
    gcpp_res_if.source o_res
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    assign o_advance = !r_valid || o_res.ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_res.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid          = r_valid;
    assign o_res.word_kind      = r_result.word_kind;
    assign o_res.header_type    = r_result.header_type;
    assign o_res.payload_count  = r_result.payload_count;
    assign o_res.reg_address    = r_result.reg_address;
    assign o_res.write_value    = r_result.write_value;
    assign o_res.opcode_tag     = r_result.opcode_tag;
    assign o_res.last_of_packet = r_result.last_of_packet;
    assign o_res.ib_request     = r_result.ib_request;
    assign o_res.ib_address     = r_result.ib_address;
    assign o_res.ib_size        = r_result.ib_size;

endmodule

[rtl/gpu_command_packet_parser_top.sv]
// Header/payload decode and counter update sit in one stage, between the input and result regs.
// Throughput: one word per cycle while the output is not stalled.
// Input ready drops only when both registers hold words and the result is not taken.
// Config channel is always ready; writes take effect on the next edge.
// Reset (sync, active low) clears parser state, the IB base latch and both config registers.
module gpu_command_packet_parser_top import gcpp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gcpp_cmd_if.sink   i_cmd,
    gcpp_cfg_if.sink   i_cfg,
    gcpp_res_if.source o_res
);

    logic    in_valid;
    t_cmd    in_cmd;
    logic    advance;
    logic    step;
    t_result result;
    t_cfg_wr cfg_wr;

    assign i_cfg.ready      = 1'b1;
    assign cfg_wr.en        = i_cfg.valid && i_cfg.ready;
    assign cfg_wr.reg_index = i_cfg.reg_index;
    assign cfg_wr.data      = i_cfg.data;

    assign step = in_valid && advance;

    gcpp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (i_cmd),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_cmd     (in_cmd)
    );

    gcpp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (cfg_wr),
        .i_step   (step),
        .i_cmd    (in_cmd),
        .o_result (result)
    );

    gcpp_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (step),
        .i_result  (result),
        .o_advance (advance),
        .o_res     (o_res)
    );

endmodule

[sim/gcpp_result_checker.sv]
module gcpp_result_checker import gcpp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gcpp_cmd_if        i_cmd,
    gcpp_cfg_if        i_cfg,
    gcpp_res_if        i_res,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked,
    output int         o_ib_requests
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CFG_W-1:0]   ib_base_addr;
    logic [CFG_W-1:0]   ib_size_addr;

    logic               in_payload;
    logic [LEFT_W-1:0]  words_left;
    logic [ADDR_W-1:0]  next_addr;
    logic               fixed_reg;
    logic [TYPE_W-1:0]  cur_type;
    logic [COUNT_W-1:0] cur_count;
    logic [OPC_W-1:0]   cur_opcode;
    logic [WORD_W-1:0]  ib_base_latch;

    t_result parsed_words_q[$];
    int      fail_cnt;
    int      checked_cnt;
    int      ib_req_cnt;

    initial begin
        fail_cnt      = 0;
        checked_cnt   = 0;
        ib_req_cnt    = 0;
    end

    task automatic decode_command_word(input logic [WORD_W-1:0] w, input logic sob,
                                       output t_result r);
        logic [ADDR_W-1:0] hdr_addr;
        r = '0;
        if (sob || !in_payload) begin
            hdr_addr   = {1'b0, w[12:0], 2'b00};
            cur_type   = w[31:30];
            cur_count  = w[29:16];
            cur_opcode = w[15:8];
            fixed_reg  = w[15];
            next_addr  = hdr_addr;
            words_left = '0;
            in_payload = 1'b0;
            case (cur_type)
                PKT_TYPE0: begin
                    r.word_kind   = KIND_HEADER;
                    r.reg_address = hdr_addr;
                    in_payload    = 1'b1;
                    words_left    = {1'b0, cur_count} + 15'd1;
                end
                PKT_TYPE1: begin
                    r.word_kind      = KIND_TYPE1_ERR;
                    r.last_of_packet = 1'b1;
                end
                PKT_TYPE2: begin
                    r.word_kind      = KIND_TYPE2_HDR;
                    r.reg_address    = hdr_addr;
                    r.last_of_packet = 1'b1;
                end
                default: begin
                    r.word_kind = KIND_HEADER;
                    in_payload  = 1'b1;
                    words_left  = {1'b0, cur_count} + 15'd1;
                end
            endcase
        end else begin
            r.write_value = w;
            if (words_left != '0) words_left = words_left - 15'd1;
            if (words_left == '0) begin
                r.last_of_packet = 1'b1;
                in_payload       = 1'b0;
            end
            if (cur_type == PKT_TYPE0) begin
                r.word_kind   = KIND_REG_WRITE;
                r.reg_address = next_addr;
                if (!fixed_reg) next_addr = next_addr + 16'd4;
                // base latch is taken before the size match
                if (r.reg_address == {1'b0, ib_base_addr}) ib_base_latch = w;
                if (r.reg_address == {1'b0, ib_size_addr}) begin
                    r.ib_request  = 1'b1;
                    r.ib_address  = ib_base_latch;
                    r.ib_size     = w;
                    ib_base_latch = '0;
                end
            end else begin
                r.word_kind = KIND_T3_PAYLOAD;
            end
        end
        r.header_type   = cur_type;
        r.payload_count = cur_count;
        r.opcode_tag    = (cur_type == PKT_TYPE3) ? cur_opcode : '0;
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                               input logic [WORD_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result predicted;
        t_result oldest;
        if (!i_rst_n) begin
            ib_base_addr  <= '0;
            ib_size_addr  <= '0;
            in_payload    = 1'b0;
            words_left    = '0;
            next_addr     = '0;
            fixed_reg     = 1'b0;
            cur_type      = '0;
            cur_count     = '0;
            cur_opcode    = '0;
            ib_base_latch = '0;
            parsed_words_q.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready) begin
                decode_command_word(i_cmd.command_word, i_cmd.start_of_buffer, predicted);
                parsed_words_q.push_back(predicted);
            end
            if (i_res.valid && i_res.ready) begin
                if (parsed_words_q.size() == 0) begin
                    $error("result transaction with no command word pending");
                    fail_cnt++;
                end else begin
                    oldest = parsed_words_q.pop_front();
                    checked_cnt++;
                    if (i_res.ib_request === 1'b1) ib_req_cnt++;
                    check_field("word_kind", 32'(oldest.word_kind), 32'(i_res.word_kind));
                    check_field("header_type", 32'(oldest.header_type),
                                32'(i_res.header_type));
                    check_field("payload_count", 32'(oldest.payload_count),
                                32'(i_res.payload_count));
                    check_field("reg_address", 32'(oldest.reg_address),
                                32'(i_res.reg_address));
                    check_field("write_value", oldest.write_value, i_res.write_value);
                    check_field("opcode_tag", 32'(oldest.opcode_tag),
                                32'(i_res.opcode_tag));
                    check_field("last_of_packet", 32'(oldest.last_of_packet),
                                32'(i_res.last_of_packet));
                    check_field("ib_request", 32'(oldest.ib_request),
                                32'(i_res.ib_request));
                    check_field("ib_address", oldest.ib_address, i_res.ib_address);
                    check_field("ib_size", oldest.ib_size, i_res.ib_size);
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.reg_index == CFG_IB_BASE) ib_base_addr <= i_cfg.data[CFG_W-1:0];
                if (i_cfg.reg_index == CFG_IB_SIZE) ib_size_addr <= i_cfg.data[CFG_W-1:0];
            end
        end
        o_fail_count  <= fail_cnt;
        o_pending     <= parsed_words_q.size();
        o_checked     <= checked_cnt;
        o_ib_requests <= ib_req_cnt;
    end

endmodule

[sim/gpu_command_packet_parser_top_tb.sv]
module gpu_command_packet_parser_top_tb;
    import gcpp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gcpp_cmd_if cmd_bus ();
    gcpp_cfg_if cfg_bus ();
    gcpp_res_if res_bus ();

    int fail_count;
    int pending;
    int checked;
    int ib_requests;

    int tx_idle_pct;
    int rx_idle_pct;
    int words_sent;
    int forced_headers;

    logic [CFG_W-1:0] ib_base_now;
    logic [CFG_W-1:0] ib_size_now;

    gpu_command_packet_parser_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .i_cfg   (cfg_bus),
        .o_res   (res_bus)
    );

    gcpp_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd_bus),
        .i_cfg         (cfg_bus),
        .i_res         (res_bus),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_ib_requests (ib_requests)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("gpu_command_packet_parser_top_tb: FAIL");
        $finish;
    end

    initial begin
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [WORD_W-1:0] type0_header(input logic [COUNT_W-1:0] cnt,
                                                       input logic fixed,
                                                       input logic [REGIDX_W-1:0] idx);
        logic [1:0] filler;
        filler = 2'($urandom);
        return {PKT_TYPE0, cnt, fixed, filler, idx};
    endfunction

    function automatic logic [WORD_W-1:0] type3_header(input logic [COUNT_W-1:0] cnt,
                                                       input logic [OPC_W-1:0] opc);
        logic [7:0] filler;
        filler = 8'($urandom);
        return {PKT_TYPE3, cnt, opc, filler};
    endfunction

    // lands a rising run on or just below one of the IB registers
    function automatic logic [REGIDX_W-1:0] pick_reg_index();
        logic [CFG_W-1:0] target;
        if ($urandom_range(99) < 40) begin
            target = $urandom_range(1) ? ib_base_now : ib_size_now;
            return target[14:2] - 13'($urandom_range(3));
        end
        return 13'($urandom);
    endfunction

    task automatic send_word(input logic [WORD_W-1:0] w, input logic sob);
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_bus.valid           <= 1'b1;
        cmd_bus.command_word    <= w;
        cmd_bus.start_of_buffer <= sob;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        words_sent++;
        if (sob) forced_headers++;
    endtask

    task automatic wait_drained();
        cmd_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_ib_regs(input logic [WORD_W-1:0] base_data,
                                 input logic [WORD_W-1:0] size_data);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.reg_index <= CFG_IB_BASE;
        cfg_bus.data      <= base_data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.reg_index <= CFG_IB_SIZE;
        cfg_bus.data      <= size_data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        cfg_bus.valid <= 1'b0;
        ib_base_now = base_data[CFG_W-1:0];
        ib_size_now = size_data[CFG_W-1:0];
    endtask

    task automatic reconfigure(input logic [WORD_W-1:0] base_data,
                               input logic [WORD_W-1:0] size_data);
        wait_drained();
        repeat (4) @(posedge i_clk);
        write_ib_regs(base_data, size_data);
    endtask

    // config here: base 0x40, size 0x44
    task automatic run_directed();
        send_word(type0_header(14'd1, 1'b0, 13'h0010), 1'b1);
        send_word(32'hDEAD_BEEF, 1'b0);
        send_word(32'h0000_0100, 1'b0);
        send_word(type0_header(14'd1, 1'b1, 13'h0011), 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(type3_header(14'd0, 8'hFF), 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(type3_header(14'd2, 8'h00), 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h1234_5678, 1'b0);
        send_word({PKT_TYPE2, 14'h3FFF, 16'hFFFF}, 1'b1);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(type0_header(14'h3FFF, 1'b0, 13'h1FFF), 1'b0);
        send_word(32'h5555_5555, 1'b0);
        send_word(32'hAAAA_AAAA, 1'b0);
        send_word(32'h0F0F_F0F0, 1'b0);
        send_word(type3_header(14'd0, 8'hA5), 1'b1);
        send_word(32'hCAFE_F00D, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic run_random(input int n_items, input int pause_at);
        int               sent;
        int               sel;
        int               n_pl;
        int               cut;
        logic [COUNT_W-1:0] cnt;
        logic [TYPE_W-1:0]  ptype;
        logic [WORD_W-1:0]  hdr;
        logic               force_hdr;
        logic               drained;
        sent      = 0;
        force_hdr = 1'b0;
        drained   = 1'b0;
        while (sent < n_items) begin
            if (!drained && sent >= pause_at) begin
                wait_drained();
                drained = 1'b1;
            end
            sel = $urandom_range(99);
            if (sel < 6 && !force_hdr) begin
                send_word($urandom & 32'hC007_FFFF, 1'($urandom_range(1)));
                sent++;
            end else begin
                sel = $urandom_range(99);
                if (sel < 45) ptype = PKT_TYPE0;
                else if (sel < 80) ptype = PKT_TYPE3;
                else if (sel < 92) ptype = PKT_TYPE2;
                else ptype = PKT_TYPE1;
                sel = $urandom_range(99);
                if (sel < 85) cnt = 14'($urandom_range(7));
                else if (sel < 97) cnt = 14'($urandom_range(40, 8));
                else cnt = '0;
                case (ptype)
                    PKT_TYPE0: hdr = type0_header(cnt, 1'($urandom_range(1)), pick_reg_index());
                    PKT_TYPE3: hdr = type3_header(cnt, 8'($urandom));
                    PKT_TYPE2: hdr = {PKT_TYPE2, 14'($urandom), 16'($urandom)};
                    default:   hdr = {PKT_TYPE1, 30'($urandom)};
                endcase
                send_word(hdr, force_hdr || ($urandom_range(9) == 0));
                sent++;
                force_hdr = 1'b0;
                if (ptype == PKT_TYPE0 || ptype == PKT_TYPE3) begin
                    n_pl = int'(cnt) + 1;
                    cut  = ($urandom_range(11) == 0) ? $urandom_range(n_pl - 1) : n_pl;
                    for (int i = 0; i < cut; i++) begin
                        send_word($urandom, 1'b0);
                        sent++;
                    end
                    force_hdr = (cut < n_pl);
                end
            end
        end
    endtask

    initial begin
        i_rst_n                 <= 1'b0;
        cmd_bus.valid           <= 1'b0;
        cmd_bus.command_word    <= '0;
        cmd_bus.start_of_buffer <= 1'b0;
        cfg_bus.valid           <= 1'b0;
        cfg_bus.reg_index       <= CFG_IB_BASE;
        cfg_bus.data            <= '0;
        tx_idle_pct    = 26;
        rx_idle_pct    = 81;
        words_sent     = 0;
        forced_headers = 0;
        ib_base_now    = '0;
        ib_size_now    = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // upper data bits are junk and must be dropped
        write_ib_regs(32'hABCD_8040, 32'h5A5A_0044);
        run_directed();

        reconfigure(32'hFFFF_8000, 32'h0000_7FFC);
        run_random(220, 110);

        tx_idle_pct = 81;
        rx_idle_pct = 26;
        reconfigure(32'h0001_8200, 32'h0000_0200);
        run_random(220, 110);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        reconfigure(32'h0000_7FFC, 32'hFFFF_8000);
        run_random(200, 100);

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d command words (%0d forced headers), checked %0d results, %0d IB requests",
                 words_sent, forced_headers, checked, ib_requests);
        $display("IB register settings: masked high bits, both extremes, base equal to size");
        if (fail_count == 0 && pending == 0) begin
            $display("gpu_command_packet_parser_top_tb: PASS");
        end else begin
            $display("gpu_command_packet_parser_top_tb: FAIL");
        end
        $finish;
    end

endmodule
